>>> rtl/jdt_pkg.sv
// ----------------------------------------------------------------------------
// jdt_pkg: shared types and constants of the job dispatch tracker
// Word layouts of both channels, the slot table entry, request codes and
// the configuration register map.
// ----------------------------------------------------------------------------
package jdt_pkg;

    localparam int JOB_W      = 16;
    localparam int WID_W      = 4;
    localparam int SIDX_W     = 6;
    localparam int WIU_W      = 5;
    localparam int LIM_W      = 7;
    localparam int COMP_W     = 16;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [WIU_W-1:0]  WIU_RESET = 5'd16;
    localparam logic [LIM_W-1:0]  LIM_RESET = 7'd64;
    localparam logic [COMP_W-1:0] COMP_MAX  = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_WORKERS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JOB_LIMIT      = 1'd1;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_FINISH = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [WID_W-1:0]  worker_index;
        logic [JOB_W-1:0]  job_number;
        logic [SIDX_W-1:0] slot_index;
    } jdt_in_t;

    typedef struct packed {
        logic [WID_W-1:0] free_worker;
        logic             free_found;
        logic             job_done;
        logic [JOB_W-1:0] slot_job;
        logic             slot_job_valid;
        logic             tasks_pending;
        logic             finish_matched;
        logic             bad_request;
    } jdt_out_t;

    // One slot: ready flag (busy otherwise), owning worker and job id.
    // An entry is only meaningful while its valid bit is set.
    typedef struct packed {
        logic             ready;
        logic [WID_W-1:0] worker;
        logic [JOB_W-1:0] job;
    } jdt_entry_t;

endpackage

>>> rtl/jdt_mod_unit.sv
// ----------------------------------------------------------------------------
// jdt_mod_unit: bit-serial remainder unit
// Restoring remainder of a job id by the job limit, one dividend bit per
// cycle through a single compare-and-subtract stage.
// ----------------------------------------------------------------------------
module jdt_mod_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [jdt_pkg::JOB_W-1:0]   dividend,
    input  logic [jdt_pkg::LIM_W-1:0]   divisor,
    output logic                        done,
    output logic [jdt_pkg::LIM_W-1:0]   remainder
);

    localparam int STEP_W = $clog2(jdt_pkg::JOB_W);

    logic                        run_reg;
    logic                        done_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [jdt_pkg::JOB_W-1:0]   dvd_reg;
    logic [jdt_pkg::LIM_W-1:0]   dvs_reg;
    logic [jdt_pkg::LIM_W-1:0]   rem_reg;

    logic [jdt_pkg::LIM_W:0]     trial;
    logic [jdt_pkg::LIM_W:0]     dvs_ext;
    logic                        fits;
    logic [jdt_pkg::LIM_W-1:0]   rem_next;

    // Shift in the next dividend bit; subtract the divisor when it fits.
    assign trial    = {rem_reg, dvd_reg[jdt_pkg::JOB_W-1]};
    assign dvs_ext  = {1'b0, dvs_reg};
    assign fits     = (trial >= dvs_ext);
    assign rem_next = fits ? jdt_pkg::LIM_W'(trial - dvs_ext) : jdt_pkg::LIM_W'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end else if (run_reg) begin
                rem_reg  <= rem_next;
                dvd_reg  <= dvd_reg << 1;
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(jdt_pkg::JOB_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/jdt_slot_mem.sv
// ----------------------------------------------------------------------------
// jdt_slot_mem: job slot table
// One write and one registered read per cycle, with a valid bit per slot
// that reset and a table clear drop at once.
// ----------------------------------------------------------------------------
module jdt_slot_mem #(
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [AW-1:0]        rd_addr,
    output jdt_pkg::jdt_entry_t  rd_entry,
    output logic                 rd_valid,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  jdt_pkg::jdt_entry_t  wr_entry,
    input  logic                 clr_all
);

    jdt_pkg::jdt_entry_t mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    jdt_pkg::jdt_entry_t rd_entry_reg;
    logic                rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clr_all) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

>>> rtl/job_dispatch_tracker_unit.sv
// ----------------------------------------------------------------------------
// job_dispatch_tracker_unit: worker and job slot tracker
// Keeps a busy bit per worker and a table of job slots, applies start,
// finish, query and clear requests, and answers each with one status word.
// ----------------------------------------------------------------------------
// One request word is handled at a time. After the accept the request runs
// through the bit-serial remainder that maps the job id onto its slot (job
// id modulo the job limit, one step per job id bit, and a hand-over of the
// result), the read of the request's own slot, an update state, the read and
// capture of the reported slot, the worker scan (one busy bit per cycle, up
// to the lowest idle worker in use, or through all workers in use when none
// is idle), the output load and the idle state that takes the next request;
// the next request can be taken in the cycle after the output load. s_ready
// is high only while no request is in work; a finished status word waits in
// the output register and the next request may be taken meanwhile. If that
// register is still full when the next status word is done, the block holds
// it and stalls for as long as m_ready stays low.
// Configuration writes (workers_in_use, job_limit) take effect at once and
// must only be issued while no request is in flight; a job_limit write also
// clears the completion count. A job limit of 0 behaves as 1 and one above
// JOB_SLOTS as JOB_SLOTS; workers_in_use above WORKERS behaves as WORKERS.
// The slot table starts empty after reset with no clearing pass.
// ----------------------------------------------------------------------------
module job_dispatch_tracker_unit #(
    parameter int WORKERS   = 16,
    parameter int JOB_SLOTS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  jdt_pkg::jdt_in_t                 s_data,
    // status channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output jdt_pkg::jdt_out_t                m_data,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [jdt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jdt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int WIDX = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int SIDX = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_RD_JOB,
        S_UPDATE,
        S_RD_SLOT,
        S_SLOT,
        S_SCAN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration and tracking state
    logic [jdt_pkg::WIU_W-1:0]  wiu_reg;
    logic [jdt_pkg::LIM_W-1:0]  lim_reg;
    logic [jdt_pkg::COMP_W-1:0] comp_reg;
    logic [WORKERS-1:0]         busy_reg;

    // request in work and its partial results
    jdt_pkg::jdt_in_t           req_reg;
    logic [SIDX-1:0]            slot_reg;
    logic                       done_reg;
    logic                       match_reg;
    logic                       bad_reg;
    logic [jdt_pkg::JOB_W-1:0]  sjob_reg;
    logic                       sjob_ok_reg;
    logic [jdt_pkg::WIU_W-1:0]  scan_reg;
    logic [jdt_pkg::WID_W-1:0]  fw_reg;
    logic                       found_reg;

    logic                       m_valid_reg;
    jdt_pkg::jdt_out_t          m_data_reg;

    // effective settings
    logic [jdt_pkg::WIU_W-1:0]  nw_eff;
    logic [jdt_pkg::LIM_W-1:0]  lim_eff;

    // remainder unit
    logic                       mod_start;
    logic                       mod_done;
    logic [jdt_pkg::LIM_W-1:0]  mod_rem;

    // slot table
    logic [SIDX-1:0]            rd_addr;
    jdt_pkg::jdt_entry_t        rd_entry;
    logic                       rd_valid;
    logic                       wr_en;
    jdt_pkg::jdt_entry_t        wr_entry;
    logic                       clr_all;

    // decode of the request in work
    logic                       is_sf;
    logic                       bad;
    logic                       ok_start;
    logic                       ok_finish;
    logic                       match;
    logic                       done_now;
    logic                       slot_in_range;
    logic                       scan_end;
    logic                       scan_idle;
    logic [WIDX-1:0]            wsel;

    // Clamp the registers to what the storage can hold.
    assign nw_eff  = (32'(wiu_reg) > WORKERS) ? jdt_pkg::WIU_W'(WORKERS) : wiu_reg;
    assign lim_eff = (lim_reg == '0) ? jdt_pkg::LIM_W'(1) :
                     (32'(lim_reg) > JOB_SLOTS) ? jdt_pkg::LIM_W'(JOB_SLOTS) : lim_reg;

    // Launch the slot remainder on the accept edge.
    assign mod_start = s_valid && s_ready;

    jdt_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_data.job_number),
        .divisor   (lim_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Read the request's own slot first, then the reported slot after the
    // update has been written.
    assign rd_addr = (state_reg == S_RD_SLOT) ? SIDX'(req_reg.slot_index) : slot_reg;

    assign is_sf     = (req_reg.func == jdt_pkg::FUNC_START) ||
                       (req_reg.func == jdt_pkg::FUNC_FINISH);
    assign bad       = is_sf && ({1'b0, req_reg.worker_index} >= nw_eff);
    assign ok_start  = (req_reg.func == jdt_pkg::FUNC_START) && !bad;
    assign ok_finish = (req_reg.func == jdt_pkg::FUNC_FINISH) && !bad;
    assign match     = ok_finish && rd_valid &&
                       (rd_entry.job == req_reg.job_number) &&
                       (rd_entry.worker == req_reg.worker_index);
    assign wsel      = WIDX'(req_reg.worker_index);

    // A start rewrites the slot as busy; a matching finish marks it ready.
    assign wr_en          = (state_reg == S_UPDATE) && (ok_start || match);
    assign wr_entry.ready  = match;
    assign wr_entry.worker = req_reg.worker_index;
    assign wr_entry.job    = req_reg.job_number;
    assign clr_all        = (state_reg == S_UPDATE) && (req_reg.func == jdt_pkg::FUNC_CLEAR);

    // Ready state of the request's slot after the update.
    always_comb begin
        if (ok_start) begin
            done_now = 1'b0;
        end else if (match) begin
            done_now = 1'b1;
        end else if (req_reg.func == jdt_pkg::FUNC_CLEAR) begin
            done_now = 1'b0;
        end else begin
            done_now = rd_valid && rd_entry.ready;
        end
    end

    jdt_slot_mem #(
        .DEPTH (JOB_SLOTS)
    ) u_slots (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (slot_reg),
        .wr_entry (wr_entry),
        .clr_all  (clr_all)
    );

    assign slot_in_range = 32'(req_reg.slot_index) < JOB_SLOTS;

    // Worker scan: one busy bit per cycle, lowest index first.
    assign scan_end  = (scan_reg >= nw_eff);
    assign scan_idle = !busy_reg[WIDX'(scan_reg)];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    state_next = S_RD_JOB;
                end
            end
            S_RD_JOB:  state_next = S_UPDATE;
            S_UPDATE:  state_next = S_RD_SLOT;
            S_RD_SLOT: state_next = S_SLOT;
            S_SLOT:    state_next = S_SCAN;
            S_SCAN: begin
                if (scan_end || scan_idle) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            wiu_reg     <= jdt_pkg::WIU_RESET;
            lim_reg     <= jdt_pkg::LIM_RESET;
            comp_reg    <= '0;
            busy_reg    <= '0;
        end else begin
            state_reg <= state_next;

            // Drop the status word once it is taken, unless S_OUT reloads it.
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg  <= s_data;
                        scan_reg <= '0;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        slot_reg <= SIDX'(mod_rem);
                    end
                end
                S_RD_JOB: begin
                end
                S_UPDATE: begin
                    if (ok_start) begin
                        busy_reg[wsel] <= 1'b1;
                    end
                    if (ok_finish) begin
                        busy_reg[wsel] <= 1'b0;
                    end
                    // Count a matching finish, saturating at the top.
                    if (match && (comp_reg != jdt_pkg::COMP_MAX)) begin
                        comp_reg <= comp_reg + jdt_pkg::COMP_W'(1);
                    end
                    done_reg  <= done_now;
                    match_reg <= match;
                    bad_reg   <= bad;
                end
                S_RD_SLOT: begin
                end
                S_SLOT: begin
                    sjob_ok_reg <= rd_valid && slot_in_range;
                    sjob_reg    <= (rd_valid && slot_in_range) ? rd_entry.job : '0;
                end
                S_SCAN: begin
                    if (scan_end) begin
                        found_reg <= 1'b0;
                        fw_reg    <= '0;
                    end else if (scan_idle) begin
                        found_reg <= 1'b1;
                        fw_reg    <= scan_reg[jdt_pkg::WID_W-1:0];
                    end else begin
                        scan_reg <= scan_reg + jdt_pkg::WIU_W'(1);
                    end
                end
                S_OUT: begin
                    // Load the status word once the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg               <= 1'b1;
                        m_data_reg.free_worker    <= fw_reg;
                        m_data_reg.free_found     <= found_reg;
                        m_data_reg.job_done       <= done_reg;
                        m_data_reg.slot_job       <= sjob_reg;
                        m_data_reg.slot_job_valid <= sjob_ok_reg;
                        m_data_reg.tasks_pending  <= (comp_reg != jdt_pkg::COMP_W'(lim_eff));
                        m_data_reg.finish_matched <= match_reg;
                        m_data_reg.bad_request    <= bad_reg;
                    end
                end
                default: begin
                end
            endcase

            // Configuration writes; a new job limit starts a fresh count.
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    jdt_pkg::CFG_WORKERS_IN_USE: begin
                        wiu_reg <= cfg_wdata[jdt_pkg::WIU_W-1:0];
                    end
                    jdt_pkg::CFG_JOB_LIMIT: begin
                        lim_reg  <= cfg_wdata[jdt_pkg::LIM_W-1:0];
                        comp_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The slot remainder always lands inside the effective job limit.
    a_mod_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (mod_rem < lim_eff))
        else $error("slot remainder not below job limit");

    // Outside configuration writes the completion count moves by at most one.
    a_comp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_wr_en |=> (comp_reg == $past(comp_reg)) ||
                       (comp_reg == $past(comp_reg) + jdt_pkg::COMP_W'(1)))
        else $error("completion count jumped");

    // A reported idle worker is one that takes part.
    a_free_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.free_found) |-> ({1'b0, m_data.free_worker} < nw_eff))
        else $error("free worker outside the workers in use");

    // A counted finish leaves its slot ready and was a legal request.
    a_match_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.finish_matched) |-> (m_data.job_done && !m_data.bad_request))
        else $error("matched finish without ready slot");

endmodule
